/* hdl/lrps_pkg.sv */
// ----------------------------------------------------------------------------
// lrps_pkg
// Shared types and codes for the latching relay pulse sequencer.
// ----------------------------------------------------------------------------
package lrps_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned EventW = 2;
  localparam int unsigned TicksW = 8;
  localparam int unsigned CoilW  = 4;

  localparam logic [ModeW-1:0] ModeInit      = 3'd0;
  localparam logic [ModeW-1:0] ModeWaitInit  = 3'd1;
  localparam logic [ModeW-1:0] ModeSet       = 3'd2;
  localparam logic [ModeW-1:0] ModeReset     = 3'd3;
  localparam logic [ModeW-1:0] ModeWaitSet   = 3'd4;
  localparam logic [ModeW-1:0] ModeWaitReset = 3'd5;

  localparam logic [EventW-1:0] EvNone  = 2'd0;
  localparam logic [EventW-1:0] EvSet   = 2'd1;
  localparam logic [EventW-1:0] EvReset = 2'd2;

  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqSet   = 2'd1;
  localparam logic [1:0] ReqReset = 2'd2;

  localparam logic [TicksW-1:0] PulseTicksReset = 8'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic       relay_index;
  } in_t;

  typedef struct packed {
    logic             set_coil_0;
    logic             reset_coil_0;
    logic             set_coil_1;
    logic             reset_coil_1;
    logic [ModeW-1:0] relay0_mode;
    logic [ModeW-1:0] relay1_mode;
    logic             event_pending;
  } out_t;

endpackage

/* hdl/latching_relay_pulse_sequencer.sv */
// An accepted result is registered into the output register, or into the skid register while the output is stalled.
// One item per cycle while in_stall_o is low; state update is a single registered pass.
// A two-entry output stage (result register plus skid) keeps input open one
// item beyond an output stall.
// Reset: relay 0 in init, relay 1 in reset, reset event pending, coils off,
// pulse_ticks 4, output empty.
// ----------------------------------------------------------------------------
// latching_relay_pulse_sequencer
// Bistable relay coil pulse driver with tick-driven countdown per pulse.
// ----------------------------------------------------------------------------
module latching_relay_pulse_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrps_pkg::TicksW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lrps_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lrps_pkg::out_t              out_data_o
);
  import lrps_pkg::*;

  logic in_acc;
  logic out_take;
  out_t res;
  out_t out_q;
  out_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  lrps_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_acc),
    .in_i       (in_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold payload while stalled; advance from skid first
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/lrps_core.sv */
// ----------------------------------------------------------------------------
// lrps_core
// Relay state, shared countdown and coil lines; one transfer per cycle.
// ----------------------------------------------------------------------------
module lrps_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrps_pkg::TicksW-1:0]   cfg_data_i,
  input  logic                          acc_i,
  input  lrps_pkg::in_t                 in_i,
  output lrps_pkg::out_t                res_o
);
  import lrps_pkg::*;

  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [ModeW-1:0]  mode0_q, mode0_d;
  logic [ModeW-1:0]  mode1_q, mode1_d;
  logic [EventW-1:0] event_q, event_d;
  logic              tgt_q, tgt_d;
  logic [TicksW-1:0] cnt_q, cnt_d;
  logic [CoilW-1:0]  coil_q, coil_d;
  logic [ModeW-1:0]  cur_mode, nxt_mode;

  assign ticks_d  = cfg_we_i ? cfg_data_i : ticks_q;
  assign cur_mode = tgt_q ? mode1_q : mode0_q;

  always_comb begin
    mode0_d  = mode0_q;
    mode1_d  = mode1_q;
    event_d  = event_q;
    tgt_d    = tgt_q;
    cnt_d    = cnt_q;
    coil_d   = coil_q;
    nxt_mode = cur_mode;
    if (acc_i) begin
      case (in_i.req_type)
        ReqTick: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
          if (event_q != EvNone) begin
            case (cur_mode)
              ModeInit: begin
                coil_d[1] = 1'b1;
                coil_d[3] = 1'b1;
                cnt_d     = ticks_q;
                nxt_mode  = ModeWaitInit;
              end
              ModeWaitInit: begin
                if (cnt_d == '0) begin
                  coil_d[1] = 1'b0;
                  coil_d[3] = 1'b0;
                  nxt_mode  = ModeReset;
                end
              end
              ModeWaitSet: begin
                if (cnt_d == '0) begin
                  coil_d[{tgt_q, 1'b0}] = 1'b0;
                  nxt_mode              = ModeSet;
                end
              end
              ModeWaitReset: begin
                if (cnt_d == '0) begin
                  coil_d[{tgt_q, 1'b1}] = 1'b0;
                  nxt_mode              = ModeReset;
                end
              end
              ModeSet: begin
                if (event_q == EvReset) begin
                  coil_d[{tgt_q, 1'b1}] = 1'b1;
                  cnt_d                 = ticks_q;
                  nxt_mode              = ModeWaitReset;
                end else begin
                  event_d = EvNone;
                end
              end
              ModeReset: begin
                if (event_q == EvSet) begin
                  coil_d[{tgt_q, 1'b0}] = 1'b1;
                  cnt_d                 = ticks_q;
                  nxt_mode              = ModeWaitSet;
                end else begin
                  event_d = EvNone;
                end
              end
              default: begin
                nxt_mode = cur_mode;
              end
            endcase
            if (tgt_q) begin
              mode1_d = nxt_mode;
            end else begin
              mode0_d = nxt_mode;
            end
          end
        end
        ReqSet: begin
          tgt_d   = in_i.relay_index;
          event_d = EvSet;
        end
        ReqReset: begin
          tgt_d   = in_i.relay_index;
          event_d = EvReset;
        end
        default: begin
          tgt_d = tgt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PulseTicksReset;
      mode0_q <= ModeInit;
      mode1_q <= ModeReset;
      event_q <= EvReset;
      tgt_q   <= 1'b0;
      cnt_q   <= '0;
      coil_q  <= '0;
    end else begin
      ticks_q <= ticks_d;
      mode0_q <= mode0_d;
      mode1_q <= mode1_d;
      event_q <= event_d;
      tgt_q   <= tgt_d;
      cnt_q   <= cnt_d;
      coil_q  <= coil_d;
    end
  end

  assign res_o.set_coil_0    = coil_d[0];
  assign res_o.reset_coil_0  = coil_d[1];
  assign res_o.set_coil_1    = coil_d[2];
  assign res_o.reset_coil_1  = coil_d[3];
  assign res_o.relay0_mode   = mode0_d;
  assign res_o.relay1_mode   = mode1_d;
  assign res_o.event_pending = (event_d != EvNone);

endmodule

/* hdl/lrps_checker.sv */
// ----------------------------------------------------------------------------
// lrps_checker
// Port-level checks for the latching relay pulse sequencer.
// ----------------------------------------------------------------------------
module lrps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input lrps_pkg::out_t              out_data_o
);
  import lrps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transfer produced no result");

  a_init_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.relay0_mode == ModeWaitInit |-> out_data_o.reset_coil_0)
    else $error("relay 0 waiting on init without reset coil");

  a_set_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.relay0_mode == ModeWaitSet |-> out_data_o.set_coil_0)
    else $error("relay 0 waiting on set without set coil");

endmodule

bind latching_relay_pulse_sequencer lrps_checker u_lrps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
